// ===== src/lprl_pkg.sv =====
// Shared types and constants for the longest-prefix route lookup block.
package lprl_pkg;

	// Default number of route slots.
	localparam int LPRL_TABLE_DEPTH = 64;

	// Field widths of the request and response items.
	localparam int ADDR_W  = 32;
	localparam int PORT_W  = 8;
	localparam int SLOT_W  = 6;
	localparam int COUNT_W = 7;

	// Request type codes.
	localparam logic REQ_WRITE  = 1'b0;
	localparam logic REQ_LOOKUP = 1'b1;

	// Register index codes of the configuration port.
	localparam logic REG_ENTRY_COUNT = 1'b0;

	// Match key of one route slot.
	typedef struct packed {
		logic [ADDR_W-1:0] prefix;
		logic [ADDR_W-1:0] mask;
	} key_t;

	// Forwarding data of one route slot.
	typedef struct packed {
		logic [ADDR_W-1:0] gateway;
		logic [PORT_W-1:0] port;
	} route_data_t;

	// Lookup sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FETCH,
		ST_RESULT
	} state_t;

endpackage

// ===== src/lprl_if.sv =====
// Request and response channel interfaces of the route lookup block.
interface lprl_req_if
	import lprl_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              req_type;
	logic [SLOT_W-1:0] entry_index;
	logic [ADDR_W-1:0] entry_prefix;
	logic [ADDR_W-1:0] entry_mask;
	logic [ADDR_W-1:0] entry_next_hop;
	logic [PORT_W-1:0] entry_port;
	logic [ADDR_W-1:0] lookup_address;

	modport source (
		output valid, req_type, entry_index, entry_prefix, entry_mask,
		       entry_next_hop, entry_port, lookup_address,
		input  ready
	);

	modport sink (
		input  valid, req_type, entry_index, entry_prefix, entry_mask,
		       entry_next_hop, entry_port, lookup_address,
		output ready
	);
endinterface

interface lprl_rsp_if
	import lprl_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              hit;
	logic [ADDR_W-1:0] route_next_hop;
	logic [PORT_W-1:0] route_port;
	logic [SLOT_W-1:0] route_slot;

	modport source (
		output valid, hit, route_next_hop, route_port, route_slot,
		input  ready
	);

	modport sink (
		input  valid, hit, route_next_hop, route_port, route_slot,
		output ready
	);
endinterface

// ===== src/longest_prefix_route_lookup.sv =====
// Top level of the IPv4 longest-prefix route lookup block.
// A write item stores a prefix, mask, next hop and port at one slot and
// does not leave the idle state. A lookup item compares the destination
// with every slot below entry_count (capped at TABLE_DEPTH) and returns the
// matching slot with the largest mask, lowest slot on a tie, or a miss. A
// lookup holds off further items from acceptance until its result enters
// the output register: the key memory has one read port and is scanned one
// slot per cycle, followed by one read of the forwarding data memory. The
// result waits in an output register, so a write item may enter while a
// result is still pending. No clearing pass is needed after reset; slots
// must be written before a lookup searches them.
module longest_prefix_route_lookup
	import lprl_pkg::*;
#(
	parameter int TABLE_DEPTH = LPRL_TABLE_DEPTH,
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
	input  logic        clk,
	input  logic        arst_n,
	lprl_req_if.sink    req,
	lprl_rsp_if.source  rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [COUNT_W-1:0] entry_count;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	key_t               wr_key;
	route_data_t        wr_data;
	logic               key_rd_en;
	logic [IDX_W-1:0]   key_rd_addr;
	key_t               key_rd;
	logic               data_rd_en;
	logic [IDX_W-1:0]   data_rd_addr;
	route_data_t        data_rd;

	lprl_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.entry_count (entry_count)
	);

	lprl_table #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_table (
		.clk          (clk),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_key       (wr_key),
		.wr_data      (wr_data),
		.key_rd_en    (key_rd_en),
		.key_rd_addr  (key_rd_addr),
		.key_rd       (key_rd),
		.data_rd_en   (data_rd_en),
		.data_rd_addr (data_rd_addr),
		.data_rd      (data_rd)
	);

	lprl_engine #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req),
		.rsp          (rsp),
		.entry_count  (entry_count),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.wr_key       (wr_key),
		.wr_data      (wr_data),
		.key_rd_en    (key_rd_en),
		.key_rd_addr  (key_rd_addr),
		.key_rd       (key_rd),
		.data_rd_en   (data_rd_en),
		.data_rd_addr (data_rd_addr),
		.data_rd      (data_rd)
	);

endmodule

// ===== src/lprl_cfg.sv =====
// APB register block holding the entry count.
module lprl_cfg
	import lprl_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output logic [COUNT_W-1:0] entry_count
);

	logic [COUNT_W-1:0] entry_count_q;
	logic               reg_index;
	logic               wr_en;

	// Decode the word index from the byte address.
	assign reg_index = paddr[2];
	assign wr_en     = psel && penable && pwrite;
	assign pready    = 1'b1;

	// Hold the entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (wr_en && (reg_index == REG_ENTRY_COUNT)) begin
			entry_count_q <= pwdata[COUNT_W-1:0];
		end
	end

	// Return the register value on reads.
	always_comb begin
		unique case (reg_index)
			REG_ENTRY_COUNT: prdata = 32'(entry_count_q);
			default:         prdata = '0;
		endcase
	end

	assign entry_count = entry_count_q;

endmodule

// ===== src/lprl_table.sv =====
// Route table storage: key memory and forwarding data memory.
module lprl_table
	import lprl_pkg::*;
#(
	parameter int TABLE_DEPTH = LPRL_TABLE_DEPTH,
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [IDX_W-1:0]  wr_addr,
	input  key_t              wr_key,
	input  route_data_t       wr_data,
	input  logic              key_rd_en,
	input  logic [IDX_W-1:0]  key_rd_addr,
	output key_t              key_rd,
	input  logic              data_rd_en,
	input  logic [IDX_W-1:0]  data_rd_addr,
	output route_data_t       data_rd
);

	key_t        key_mem  [TABLE_DEPTH];
	route_data_t data_mem [TABLE_DEPTH];
	key_t        key_rd_q;
	route_data_t data_rd_q;

	// Write both memories at the slot of a write item.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr]  <= wr_key;
			data_mem[wr_addr] <= wr_data;
		end
	end

	// Read the key of the slot under scan.
	always_ff @(posedge clk) begin
		if (key_rd_en) begin
			key_rd_q <= key_mem[key_rd_addr];
		end
	end

	// Read the forwarding data of the best slot.
	always_ff @(posedge clk) begin
		if (data_rd_en) begin
			data_rd_q <= data_mem[data_rd_addr];
		end
	end

	assign key_rd  = key_rd_q;
	assign data_rd = data_rd_q;

endmodule

// ===== src/lprl_engine.sv =====
// Lookup sequencer: takes items, scans the key memory and builds results.
module lprl_engine
	import lprl_pkg::*;
#(
	parameter int TABLE_DEPTH = LPRL_TABLE_DEPTH,
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	lprl_req_if.sink           req,
	lprl_rsp_if.source         rsp,
	input  logic [COUNT_W-1:0] entry_count,
	output logic               wr_en,
	output logic [IDX_W-1:0]   wr_addr,
	output key_t               wr_key,
	output route_data_t        wr_data,
	output logic               key_rd_en,
	output logic [IDX_W-1:0]   key_rd_addr,
	input  key_t               key_rd,
	output logic               data_rd_en,
	output logic [IDX_W-1:0]   data_rd_addr,
	input  route_data_t        data_rd
);

	state_t            state_q, state_d;
	logic [ADDR_W-1:0] addr_q;
	logic [CNT_W-1:0]  limit_q;
	logic [CNT_W-1:0]  limit_d;
	logic [CNT_W-1:0]  rd_idx_q;
	logic              valid_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic              found_q;
	logic [ADDR_W-1:0] best_mask_q;
	logic [IDX_W-1:0]  best_q;
	logic              issue;
	logic              match;
	logic              better;
	logic              accept;
	logic              out_free;
	logic              load_out;
	logic              slot_ok;

	logic              out_valid_q;
	logic              out_hit_q;
	logic [ADDR_W-1:0] out_gateway_q;
	logic [PORT_W-1:0] out_port_q;
	logic [SLOT_W-1:0] out_slot_q;

	// Accept an item only between lookups.
	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;

	// Store a route entry when the slot lies inside the table.
	assign slot_ok = (32'(req.entry_index) < 32'(TABLE_DEPTH));
	assign wr_en   = accept && (req.req_type == REQ_WRITE) && slot_ok;
	assign wr_addr = IDX_W'(req.entry_index);
	assign wr_key  = '{prefix: req.entry_prefix, mask: req.entry_mask};
	assign wr_data = '{gateway: req.entry_next_hop, port: req.entry_port};

	// Saturate the search limit at the table depth.
	assign limit_d = (32'(entry_count) > 32'(TABLE_DEPTH)) ?
		CNT_W'(TABLE_DEPTH) : CNT_W'(entry_count);

	// Issue one key read per cycle until the limit is reached.
	assign issue       = (state_q == ST_SCAN) && (rd_idx_q < limit_q);
	assign key_rd_en   = issue;
	assign key_rd_addr = rd_idx_q[IDX_W-1:0];

	// Compare the returned key against the address.
	assign match  = ((addr_q ^ key_rd.prefix) & key_rd.mask) == '0;
	assign better = !found_q || (key_rd.mask > best_mask_q);

	assign data_rd_en   = (state_q == ST_FETCH);
	assign data_rd_addr = best_q;

	// Output slot is free when empty or being drained.
	assign out_free = !out_valid_q || rsp.ready;

	// Sequence the lookup.
	always_comb begin
		state_d  = state_q;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (req.req_type == REQ_LOOKUP)) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (!issue) begin
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: begin
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Track the read pipeline stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q[IDX_W-1:0];
	end

	// Capture the lookup and advance the scan index.
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q   <= req.lookup_address;
			limit_q  <= limit_d;
			rd_idx_q <= '0;
		end else if (issue) begin
			rd_idx_q <= rd_idx_q + 1'b1;
		end
	end

	// Keep the best match so far.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (accept) begin
			found_q <= 1'b0;
		end else if (valid_s1 && match) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			best_mask_q <= '0;
			best_q      <= '0;
		end else if (valid_s1 && match && better) begin
			best_mask_q <= key_rd.mask;
			best_q      <= idx_s1;
		end
	end

	// Hold the result until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_hit_q     <= found_q;
			out_gateway_q <= found_q ? data_rd.gateway : '0;
			out_port_q    <= found_q ? data_rd.port : '0;
			out_slot_q    <= found_q ? SLOT_W'(best_q) : '0;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.hit            = out_hit_q;
	assign rsp.route_next_hop = out_gateway_q;
	assign rsp.route_port     = out_port_q;
	assign rsp.route_slot     = out_slot_q;

endmodule

// ===== dv/tb_longest_prefix_route_lookup.sv =====
// Self-checking testbench for the longest-prefix route lookup block.
module tb_longest_prefix_route_lookup;
	import lprl_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_DEPTH     = LPRL_TABLE_DEPTH;
	localparam int NUM_PHASES      = 12;
	localparam int ITEMS_PER_PHASE = 150;
	localparam int TAIL_CYCLES     = 80;
	localparam int HOLD_CYCLES     = 600;
	localparam int CYCLE_LIMIT     = 1000000;

	// Byte addresses on the configuration port
	localparam logic [2:0] ADDR_ENTRY_COUNT = {REG_ENTRY_COUNT, 2'b00};
	localparam logic [2:0] ADDR_SPARE       = 3'h4;

	// Base networks that random prefixes cluster around, to force overlaps
	localparam logic [ADDR_W-1:0] NET_POOL [4] = '{
		32'h0A00_0000, 32'hC0A8_0000, 32'hAC10_0000, 32'h0808_0800
	};

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	typedef struct {
		logic              req_type;
		logic [SLOT_W-1:0] entry_index;
		logic [ADDR_W-1:0] entry_prefix;
		logic [ADDR_W-1:0] entry_mask;
		logic [ADDR_W-1:0] entry_next_hop;
		logic [PORT_W-1:0] entry_port;
		logic [ADDR_W-1:0] lookup_address;
	} route_req_t;

	typedef struct {
		logic              hit;
		logic [ADDR_W-1:0] gateway;
		logic [PORT_W-1:0] port;
		logic [SLOT_W-1:0] slot;
	} route_result_t;

	// Route table mirror, longest-prefix predictor and result checker
	class lpm_scoreboard;
		bit [ADDR_W-1:0]  prefix_mem [TABLE_DEPTH];
		bit [ADDR_W-1:0]  mask_mem   [TABLE_DEPTH];
		bit [ADDR_W-1:0]  hop_mem    [TABLE_DEPTH];
		bit [PORT_W-1:0]  port_mem   [TABLE_DEPTH];
		bit               written    [TABLE_DEPTH];
		bit [COUNT_W-1:0] entry_count;
		route_result_t    expected_routes [$];
		int               errors;

		function void note_request(input route_req_t it);
			route_result_t exp;
			int            limit;
			bit            found;
			int            best;
			if (it.req_type == REQ_WRITE) begin
				prefix_mem[it.entry_index] = it.entry_prefix;
				mask_mem[it.entry_index]   = it.entry_mask;
				hop_mem[it.entry_index]    = it.entry_next_hop;
				port_mem[it.entry_index]   = it.entry_port;
				written[it.entry_index]    = 1'b1;
				return;
			end
			// Search saturates at the table depth
			limit = (entry_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count);
			found = 1'b0;
			best  = 0;
			for (int i = 0; i < limit; i++) begin
				if ((it.lookup_address & mask_mem[i]) == (prefix_mem[i] & mask_mem[i])) begin
					// Strictly larger mask wins, so ties keep the lowest slot
					if (!found || mask_mem[i] > mask_mem[best]) begin
						best  = i;
						found = 1'b1;
					end
				end
			end
			exp.hit     = found;
			exp.gateway = found ? hop_mem[best] : '0;
			exp.port    = found ? port_mem[best] : '0;
			exp.slot    = found ? SLOT_W'(best) : '0;
			expected_routes.push_back(exp);
		endfunction

		function void check_route(input route_result_t got);
			route_result_t exp;
			if (expected_routes.size() == 0) begin
				$display("%0t: route result with no lookup pending: hit %0b hop %h port %h slot %0d",
					$time, got.hit, got.gateway, got.port, got.slot);
				errors++;
				return;
			end
			exp = expected_routes.pop_front();
			if (got.hit !== exp.hit) begin
				$display("%0t: hit mismatch: expected %0b, got %0b", $time, exp.hit, got.hit);
				errors++;
			end
			if (got.gateway !== exp.gateway) begin
				$display("%0t: route_next_hop mismatch: expected %h, got %h",
					$time, exp.gateway, got.gateway);
				errors++;
			end
			if (got.port !== exp.port) begin
				$display("%0t: route_port mismatch: expected %h, got %h",
					$time, exp.port, got.port);
				errors++;
			end
			if (got.slot !== exp.slot) begin
				$display("%0t: route_slot mismatch: expected %0d, got %0d",
					$time, exp.slot, got.slot);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	lprl_req_if req_ch ();
	lprl_rsp_if rsp_ch ();

	lpm_scoreboard sb;
	route_result_t rsp_seen;
	int            send_idle_pct;
	int            recv_stall_pct;
	int            hold_requests;
	int            phase_count [NUM_PHASES] = '{1, 64, 127, 0, 65, 2, -1, 64, -1, 33, 100, -1};

	longest_prefix_route_lookup uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Result sink: random stalls plus an occasional long hold-off
	initial begin
		int hold_left;
		int holds_started;
		hold_left     = 0;
		holds_started = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left != 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left = hold_left - 1;
			end else if (holds_started != hold_requests) begin
				rsp_ch.ready <= 1'b0;
				hold_left     = HOLD_CYCLES;
				holds_started = holds_started + 1;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Check every accepted result
	always @(posedge clk) begin
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			rsp_seen.hit     = rsp_ch.hit;
			rsp_seen.gateway = rsp_ch.route_next_hop;
			rsp_seen.port    = rsp_ch.route_port;
			rsp_seen.slot    = rsp_ch.route_slot;
			sb.check_route(rsp_seen);
		end
	end

	// Watchdog
	initial begin
		int unsigned cycle_count;
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count >= CYCLE_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	function automatic void set_idle(input idle_mode_t mode);
		send_idle_pct  = (mode == IDLE_SEND) ? 79 : (mode == IDLE_BOTH) ? 24 : 0;
		recv_stall_pct = (mode == IDLE_RECV) ? 79 : (mode == IDLE_BOTH) ? 24 : 0;
	endfunction

	// Offer one item, idle first at random, and hold it until accepted
	task automatic send_item(input route_req_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid          <= 1'b1;
		req_ch.req_type       <= it.req_type;
		req_ch.entry_index    <= it.entry_index;
		req_ch.entry_prefix   <= it.entry_prefix;
		req_ch.entry_mask     <= it.entry_mask;
		req_ch.entry_next_hop <= it.entry_next_hop;
		req_ch.entry_port     <= it.entry_port;
		req_ch.lookup_address <= it.lookup_address;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		sb.note_request(it);
	endtask

	// Drop valid, wait for every expected result, then let the block go quiet
	task automatic settle();
		req_ch.valid <= 1'b0;
		while (sb.expected_routes.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic apb_cycle(input bit wr, input logic [2:0] addr, input logic [31:0] data,
			output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Write a register, then read entry_count back
	task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
		logic [31:0] rdata;
		apb_cycle(1'b1, addr, data, rdata);
		if (addr == ADDR_ENTRY_COUNT)
			sb.entry_count = data[COUNT_W-1:0];
		apb_cycle(1'b0, ADDR_ENTRY_COUNT, '0, rdata);
		if (rdata !== 32'(sb.entry_count)) begin
			$display("%0t: entry_count readback mismatch: expected %h, got %h",
				$time, 32'(sb.entry_count), rdata);
			sb.errors++;
		end
	endtask

	function automatic logic [ADDR_W-1:0] make_mask();
		int len;
		int pick;
		pick = $urandom_range(99);
		if (pick < 20)
			return $urandom;
		len = (pick < 55) ? 8 * $urandom_range(1, 3) : $urandom_range(0, 32);
		return ~(32'hFFFF_FFFF >> len);
	endfunction

	function automatic route_req_t make_write(input int slot);
		route_req_t it;
		it.req_type       = REQ_WRITE;
		it.entry_index    = SLOT_W'(slot);
		it.entry_mask     = make_mask();
		it.entry_prefix   = ($urandom_range(1) == 1) ?
			(NET_POOL[$urandom_range(0, 3)] ^ ($urandom & 32'h0000_0303)) : $urandom;
		it.entry_next_hop = $urandom;
		it.entry_port     = PORT_W'($urandom);
		it.lookup_address = $urandom;
		return it;
	endfunction

	// Mostly aim the address at a searched entry so that hits are common
	function automatic route_req_t make_lookup(input int limit);
		route_req_t it;
		int         s;
		it                = make_write($urandom_range(0, TABLE_DEPTH - 1));
		it.req_type       = REQ_LOOKUP;
		it.lookup_address = $urandom;
		if (limit > 0 && $urandom_range(99) < 75) begin
			s = $urandom_range(0, limit - 1);
			it.lookup_address = (sb.prefix_mem[s] & sb.mask_mem[s]) |
				($urandom & ~sb.mask_mem[s]);
		end
		return it;
	endfunction

	task automatic write_entry(input int slot, input logic [31:0] prefix,
			input logic [31:0] mask, input logic [31:0] hop, input logic [7:0] port);
		route_req_t it;
		it                = make_write(slot);
		it.entry_prefix   = prefix;
		it.entry_mask     = mask;
		it.entry_next_hop = hop;
		it.entry_port     = port;
		send_item(it);
	endtask

	task automatic lookup(input logic [31:0] addr);
		route_req_t it;
		it                = make_lookup(0);
		it.lookup_address = addr;
		send_item(it);
	endtask

	// Zero count, default route, host route, ties, noncontiguous masks, table ends
	task automatic run_directed();
		set_idle(IDLE_NONE);
		lookup(32'h0000_0000);
		lookup(32'hFFFF_FFFF);
		write_entry(0,  32'hDEAD_BEEF, 32'h0000_0000, 32'h0A00_0001, 8'h01);
		write_entry(1,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
		write_entry(2,  32'h0A01_0000, 32'hFFFF_0000, 32'h0A00_00FE, 8'h02);
		write_entry(3,  32'h0A01_FFFF, 32'hFFFF_0000, 32'h0A00_00FD, 8'h03);
		write_entry(4,  32'h0A01_0200, 32'hFFFF_FF00, 32'h0A00_0004, 8'h04);
		write_entry(5,  32'hC000_0000, 32'hF000_0000, 32'hC000_0001, 8'h05);
		write_entry(6,  32'hC000_0000, 32'h0FFF_FFFF, 32'hC000_0002, 8'h06);
		write_entry(62, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 8'h00);
		write_entry(63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
		settle();
		cfg_write(ADDR_SPARE, 32'hFFFF_FFFF);
		cfg_write(ADDR_ENTRY_COUNT, 32'hFFFF_FF87);
		lookup(32'hFFFF_FFFF);
		lookup(32'h0A01_0203);
		lookup(32'h0A01_FF00);
		lookup(32'hC000_0000);
		lookup(32'h1234_5678);
		lookup(32'h0000_0000);
		settle();
	endtask

	// One count setting: fill the searched slots, program, then mixed traffic
	task automatic run_phase(input int p);
		int target;
		int fill_to;
		target  = (phase_count[p] < 0) ? $urandom_range(0, 127) : phase_count[p];
		fill_to = (target > TABLE_DEPTH) ? TABLE_DEPTH : target;
		set_idle(idle_mode_t'(p % 4));
		for (int s = 0; s < fill_to; s++) begin
			if (!sb.written[s])
				send_item(make_write(s));
		end
		settle();
		if (p % 3 == 1)
			cfg_write(ADDR_SPARE, $urandom);
		cfg_write(ADDR_ENTRY_COUNT, ($urandom & ~32'h7F) | 32'(target));
		// Stall the result side long enough to back the block up
		if (p == 0)
			hold_requests++;
		for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
			if ($urandom_range(99) < 30)
				send_item(make_write($urandom_range(0, TABLE_DEPTH - 1)));
			else
				send_item(make_lookup(fill_to));
		end
		settle();
	endtask

	initial begin
		sb = new();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_requests  = 0;
		arst_n  <= 1'b0;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= '0;
		pwdata  <= '0;
		req_ch.valid          <= 1'b0;
		req_ch.req_type       <= REQ_WRITE;
		req_ch.entry_index    <= '0;
		req_ch.entry_prefix   <= '0;
		req_ch.entry_mask     <= '0;
		req_ch.entry_next_hop <= '0;
		req_ch.entry_port     <= '0;
		req_ch.lookup_address <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		for (int p = 0; p < NUM_PHASES; p++)
			run_phase(p);
		if (sb.errors == 0 && sb.expected_routes.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
